// ----- src/ketw_pkg.sv -----
`default_nettype none

package ketw_pkg;

	localparam int KEY_W    = 8;
	localparam int KEY_SPAN = 1 << KEY_W;
	localparam int COUNT_W  = 16;
	localparam int PERIOD_W = 16;
	localparam int NOW_W    = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] THR_MIN   = COUNT_W'(2);

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               report;
	} result_t;

endpackage

`default_nettype wire

// ----- src/ketw_ram.sv -----
`default_nettype none

module ketw_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- src/keyed_event_threshold_window_unit.sv -----
// s1 registers an event and its ram read, res_q its result; throughput: one event
// per cycle barring out_stall; the single read port of the entry ram sets it,
// and a bypass of the write in flight keeps same-key events back to back
// reset: arst_n clears the per-entry valid flops, so the table reads empty at once
// with no clearing pass; entry ram contents are not reset
`default_nettype none

module keyed_event_threshold_window_unit import ketw_pkg::*; #(
	parameter int KEY_ENTRIES = 256,
	parameter int TIME_BITS   = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [KEY_W-1:0]    key_index,
	input  wire logic [COUNT_W-1:0]  threshold_count,
	input  wire logic [PERIOD_W-1:0] window_period,
	input  wire logic [NOW_W-1:0]    now_time,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [COUNT_W-1:0]       event_count,
	output logic                     report
);

	// keys above the table wrap; only the first KEY_SPAN entries can ever be hit
	localparam int DEPTH  = (KEY_ENTRIES < KEY_SPAN) ? KEY_ENTRIES : KEY_SPAN;
	localparam int AW     = $clog2(DEPTH);
	localparam int WORD_W = COUNT_W + TIME_BITS;

	logic [AW-1:0] key_map [KEY_SPAN];

	for (genvar g = 0; g < KEY_SPAN; g++) begin : g_key_map
		localparam int KeyMod = g % KEY_ENTRIES;
		assign key_map[g] = AW'(KeyMod);
	end

	logic                 accept;
	logic                 adv;
	logic [AW-1:0]        key_in;

	logic                 valid_s1;
	logic [AW-1:0]        key_s1;
	logic [COUNT_W-1:0]   thr_s1;
	logic [PERIOD_W-1:0]  period_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 hit_s1;
	logic [WORD_W-1:0]    byp_s1;

	logic [DEPTH-1:0]     valid_q;
	logic                 out_valid_q;
	result_t              res_q;

	logic [WORD_W-1:0]    rd_word;
	logic [WORD_W-1:0]    cur_word;
	logic [COUNT_W-1:0]   cur_cnt;
	logic [TIME_BITS-1:0] cur_exp;
	logic [TIME_BITS-1:0] diff;
	logic                 win_open;
	logic                 disabled;
	logic                 ent_valid;
	logic [COUNT_W-1:0]   inc_cnt;
	logic                 wr_en;
	logic                 set_valid;
	logic [COUNT_W-1:0]   wr_count;
	logic [TIME_BITS-1:0] wr_exp;
	logic [WORD_W-1:0]    wr_word;
	result_t              res_d;

	assign key_in   = key_map[key_index];
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	ketw_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(key_s1),
		.wr_data(wr_word),
		.rd_en  (accept),
		.rd_addr(key_in),
		.rd_data(rd_word)
	);

	// entry written at the same edge as this read comes from the bypass
	assign cur_word  = hit_s1 ? byp_s1 : rd_word;
	assign cur_cnt   = cur_word[WORD_W-1:TIME_BITS];
	assign cur_exp   = cur_word[TIME_BITS-1:0];
	assign diff      = cur_exp - now_s1;
	assign win_open  = (diff != '0) && !diff[TIME_BITS-1];
	assign disabled  = (thr_s1 < THR_MIN) || (period_s1 == '0);
	assign ent_valid = valid_q[key_s1];
	assign inc_cnt   = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_ONE;

	always_comb begin
		res_d.count  = COUNT_ONE;
		res_d.report = 1'b0;
		set_valid    = 1'b0;
		wr_count     = COUNT_ONE;
		wr_exp       = now_s1 + TIME_BITS'(period_s1);
		if (disabled) begin
			res_d.report = 1'b1;
		end else if (!ent_valid) begin
			set_valid = 1'b1;
		end else if (win_open) begin
			res_d.count = inc_cnt;
			if (inc_cnt >= thr_s1) begin
				// threshold reached: clear and force the window expired
				res_d.report = 1'b1;
				wr_count     = '0;
				wr_exp       = now_s1 - TIME_BITS'(1);
			end else begin
				wr_count = inc_cnt;
				wr_exp   = cur_exp;
			end
		end
	end

	assign wr_en   = valid_s1 && adv && !disabled;
	assign wr_word = {wr_count, wr_exp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			hit_s1      <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				hit_s1   <= wr_en && (key_s1 == key_in);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en && set_valid) begin
				valid_q[key_s1] <= 1'b1;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1    <= key_in;
			thr_s1    <= threshold_count;
			period_s1 <= window_period;
			now_s1    <= TIME_BITS'(now_time);
			byp_s1    <= wr_word;
		end
		if (adv && valid_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_count = res_q.count;
	assign report      = res_q.report;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with no item in flight");

	// a held item keeps the bypass flag it was given at its transfer
	a_bypass_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 && valid_s1 |-> $past(accept) || $past(in_stall))
		else $error("bypass flag without a matching read");

	a_write_only_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> valid_s1 && !disabled)
		else $error("table written by a disabled or empty slot");

	a_report_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !disabled && res_d.report |-> res_d.count >= THR_MIN)
		else $error("thresholded report below two events");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result shown with no item behind it");
`endif

endmodule

`default_nettype wire
